/* hw/rtl/mcf_pkg.sv */
// ----------------------------------------------------------------------------
// mcf_pkg: shared types, constants and functions for the motor command framer
// Frame layout constants, the held command type and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mcf_pkg;

   // frame geometry
   localparam int FRAME_LEN = 33;
   localparam int CRC_SPAN  = 31;
   localparam int POS_W     = $clog2(FRAME_LEN);

   // CRC-16/CCITT-FALSE
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // byte positions with nonzero content
   localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(1);
   localparam logic [POS_W-1:0] POS_PARAM  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_ENABLE = POS_W'(6);
   localparam logic [POS_W-1:0] POS_SPEED  = POS_W'(7);
   localparam logic [POS_W-1:0] POS_DIR    = POS_W'(8);
   localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(CRC_SPAN);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

   localparam logic [7:0] PARAM_CODE = 8'h01;

   // one motor command as held during its frame
   typedef struct packed {
      logic       motor_stop;
      logic       forward;
      logic [7:0] speed;
   } cmd_type;

   // control from the sequencer to the CRC unit
   typedef struct packed {
      logic advance;
      logic first;
   } crc_ctrl_type;

   // frame byte at a payload position (positions before the CRC)
   function automatic logic [7:0] frame_data(input logic [POS_W-1:0] pos,
                                             input cmd_type cmd);
      logic [7:0] b;
      b = 8'h00;
      unique case (pos)
         POS_LEN_LO: b = 8'(FRAME_LEN);
         POS_PARAM:  b = PARAM_CODE;
         POS_ENABLE: b = {7'b0, ~cmd.motor_stop};
         POS_SPEED:  b = cmd.speed;
         POS_DIR:    b = {7'b0, cmd.forward};
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

   // CRC update by one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hw/rtl/mcf_if.sv */
// ----------------------------------------------------------------------------
// mcf_if: valid/ready channels of the motor command framer
// Command channel and frame byte channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface mcf_req_if;
   import mcf_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] speed;
   logic       forward;
   logic       motor_stop;

   modport source (output valid, output speed, output forward, output motor_stop,
                   input ready);
   modport sink   (input valid, input speed, input forward, input motor_stop,
                   output ready);
endinterface

interface mcf_rsp_if;
   import mcf_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

/* hw/rtl/mcf_crc_unit.sv */
// ----------------------------------------------------------------------------
// mcf_crc_unit: running CRC-16/CCITT-FALSE over the frame bytes
// Folds one byte per cycle while ctrl.advance is set; restarts on the first byte.
// ----------------------------------------------------------------------------
module mcf_crc_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  mcf_pkg::crc_ctrl_type ctrl,
   input  logic [7:0]            data,
   output logic [15:0]           crc
);
   import mcf_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] seed;

   // first byte of a frame starts from the initial value
   assign seed   = ctrl.first ? CRC_INIT : crc_ff;
   assign crc_in = ctrl.advance ? crc_byte(seed, data) : crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !ctrl.advance |=> crc_ff == $past(crc_ff))
      else $error("crc changed without a byte");

endmodule

/* hw/rtl/motor_command_frame_crc16.sv */
// ----------------------------------------------------------------------------
// motor_command_frame_crc16: framed motor command with CRC-16/CCITT-FALSE
// Turns each motor command into a 33-byte frame sent one byte per item.
// ----------------------------------------------------------------------------
//  channel | dir | payload                         | handshake
//  req     | in  | speed[7:0] forward motor_stop   | valid/ready
//  rsp     | out | frame_byte[7:0] frame_last      | valid/ready
//
//  Each command yields 33 frame bytes, one per cycle while rsp is ready.
//  The next command is taken in the cycle the last byte of the current
//  frame is loaded, so frames follow each other without a gap.
//  The CRC folds in one byte per cycle as bytes 0..30 go out.
//  Synchronous active-high reset clears the sequencer and output valid.
//  A stalled rsp holds the output register and the byte position.
// ----------------------------------------------------------------------------
module motor_command_frame_crc16 (
   input  logic       clock,
   input  logic       reset,
   mcf_req_if.sink    req,
   mcf_rsp_if.source  rsp
);
   import mcf_pkg::*;

   cmd_type          cmd_ff, cmd_in;
   logic             cmd_valid_ff, cmd_valid_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;

   logic             advance;
   logic             at_end;
   logic             req_take;
   logic [7:0]       data_byte;
   logic [15:0]      crc;
   crc_ctrl_type     crc_ctrl;

   // sequencer moves when a command is held and the output slot is free
   assign advance  = cmd_valid_ff && (!out_valid_ff || rsp.ready);
   assign at_end   = (pos_ff == POS_LAST);
   assign req.ready = !cmd_valid_ff || (advance && at_end);
   assign req_take = req.valid && req.ready;

   // byte for the current position
   assign data_byte = frame_data(pos_ff, cmd_ff);
   always_comb begin
      priority if (pos_ff < POS_CRC_HI) begin
         byte_in = data_byte;
      end else if (pos_ff == POS_CRC_HI) begin
         byte_in = crc[15:8];
      end else begin
         byte_in = crc[7:0];
      end
   end

   assign crc_ctrl.advance = advance && (pos_ff < POS_CRC_HI);
   assign crc_ctrl.first   = (pos_ff == '0);

   mcf_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .data  (data_byte),
      .crc   (crc)
   );

   // next-state logic
   always_comb begin
      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         pos_in = at_end ? '0 : pos_ff + POS_W'(1);
         if (at_end) begin
            cmd_valid_in = 1'b0;
         end
         out_valid_in = 1'b1;
         last_in      = at_end;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (req_take) begin
         cmd_in.speed      = req.speed;
         cmd_in.forward    = req.forward;
         cmd_in.motor_stop = req.motor_stop;
         cmd_valid_in      = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      last_ff <= last_in;
      if (advance) begin
         byte_ff <= byte_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.frame_byte = byte_ff;
   assign rsp.frame_last = last_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("byte position past end of frame");

   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !cmd_valid_ff |-> pos_ff == '0)
      else $error("byte position nonzero with no command held");

   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      advance && at_end && !req_take |=> !cmd_valid_ff)
      else $error("command still held after its last byte");

   a_load: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("output not valid after a byte was loaded");

endmodule

/* tb/sv/tb_motor_command_frame_crc16.sv */
// ----------------------------------------------------------------------------
// tb_motor_command_frame_crc16: testbench for the motor command framer
// Sends motor commands with random idling on both channels. Each command's
// 33-byte frame and its CRC-16 are predicted, and every frame byte that comes
// out is checked in order. A long hold-off on the frame side fills the block
// so that it stalls the command side.
// ----------------------------------------------------------------------------
module tb_motor_command_frame_crc16;
   import mcf_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_CMDS  = 250;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 2 * FRAME_LEN;
   localparam int HOLD_AFTER   = 1500;  // frame bytes seen before the long hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;
   localparam int DIRECTED_N   = 14;

   typedef logic [7:0] frame_type [FRAME_LEN];

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   // one directed command; typed rows carry the payload bytes to expect
   typedef struct packed {
      logic       typed;
      logic [7:0] speed;
      logic       forward;
      logic       motor_stop;
      logic [7:0] enable_byte;
      logic [7:0] speed_byte;
      logic [7:0] dir_byte;
      logic [5:0] gap;
   } cmd_row_type;

   // typed, speed, forward, stop, enable, speed byte, dir byte, gap
   cmd_row_type directed_rows [DIRECTED_N] = '{
      '{1'b1, 8'h00, 1'b0, 1'b0, 8'h01, 8'h00, 8'h00, 6'd3},   // first after reset
      '{1'b1, 8'hFF, 1'b1, 1'b1, 8'h00, 8'hFF, 8'h01, 6'd0},   // all ones
      '{1'b1, 8'hFF, 1'b0, 1'b0, 8'h01, 8'hFF, 8'h00, 6'd0},
      '{1'b1, 8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h01, 6'd5},
      '{1'b1, 8'h80, 1'b1, 1'b0, 8'h01, 8'h80, 8'h01, 6'd1},
      '{1'b1, 8'h01, 1'b0, 1'b1, 8'h00, 8'h01, 8'h00, 6'd0},
      '{1'b0, 8'h55, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'd0},   // back to back
      '{1'b0, 8'hAA, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 6'd0},
      '{1'b0, 8'h55, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 6'd0},
      '{1'b0, 8'hAA, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 6'd2},
      '{1'b0, 8'h7F, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 6'd0},
      '{1'b0, 8'hFE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'd40},  // long gap
      '{1'b0, 8'h0F, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 6'd0},
      '{1'b0, 8'hF0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 6'd1}
   };

   logic           clock;
   logic           reset;
   frame_byte_type pending_frame_bytes [$];
   int             bytes_seen;
   int             errors;
   int             cycle_count;
   logic           hold_done;
   cmd_type        cmd;
   frame_type      frame;

   mcf_req_if req_bus ();
   mcf_rsp_if rsp_bus ();

   motor_command_frame_crc16 DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // idle length: mostly short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // payload bytes of a frame, CRC bytes still zero
   function automatic frame_type command_frame(input cmd_type c);
      frame_type f;
      foreach (f[i]) f[i] = 8'h00;
      f[POS_LEN_LO] = 8'(FRAME_LEN);
      f[POS_PARAM]  = PARAM_CODE;
      f[POS_ENABLE] = c.motor_stop ? 8'h00 : 8'h01;
      f[POS_SPEED]  = c.speed;
      f[POS_DIR]    = {7'b0, c.forward};
      return f;
   endfunction

   // CRC-16/CCITT-FALSE over the payload, one bit at a time, MSB first
   function automatic logic [15:0] payload_crc(input frame_type f);
      logic [15:0] c;
      logic        fb;
      c = CRC_INIT;
      for (int i = 0; i < CRC_SPAN; i++) begin
         for (int b = 7; b >= 0; b--) begin
            fb = c[15] ^ f[i][b];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
         end
      end
      return c;
   endfunction

   // complete the frame with its CRC and queue its bytes in transmit order
   task automatic queue_frame(input frame_type f);
      logic [15:0] crc;
      crc = payload_crc(f);
      f[POS_CRC_HI] = crc[15:8];
      f[POS_LAST]   = crc[7:0];
      for (int k = 0; k < FRAME_LEN; k++) begin
         pending_frame_bytes.push_back('{data: f[k], last: (k == FRAME_LEN - 1)});
      end
   endtask

   // offer one command until taken, then idle for the given gap, if any
   task automatic send_command(input cmd_type c, input frame_type f, input int gap);
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.speed      <= c.speed;
      req_bus.forward    <= c.forward;
      req_bus.motor_stop <= c.motor_stop;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      queue_frame(f);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic note_error(input string what, input logic [7:0] want,
                             input logic [7:0] got);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("mismatch, %s at frame byte %0d: expected %h, got %h",
                  what, bytes_seen, want, got);
      end
   endtask

   // frame byte checker
   always @(posedge clock) begin : check_bytes
      frame_byte_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_frame_bytes.size() == 0) begin
            note_error("unexpected item", 8'h00, rsp_bus.frame_byte);
         end else begin
            want = pending_frame_bytes.pop_front();
            if (rsp_bus.frame_byte !== want.data) begin
               note_error("frame_byte", want.data, rsp_bus.frame_byte);
            end
            if (rsp_bus.frame_last !== want.last) begin
               note_error("frame_last", {7'b0, want.last}, {7'b0, rsp_bus.frame_last});
            end
         end
         bytes_seen++;
      end
   end

   // frame side: random ready runs, and one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      hold_done     = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && bytes_seen >= HOLD_AFTER) begin
            rsp_bus.ready <= 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if ($urandom_range(0, 99) < 65) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat (idle_length()) @(negedge clock);
         end
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // command side: directed table, then random commands
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.speed      = 8'h00;
      req_bus.forward    = 1'b0;
      req_bus.motor_stop = 1'b0;
      reset              = 1'b1;
      bytes_seen         = 0;
      errors             = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         cmd.speed      = directed_rows[i].speed;
         cmd.forward    = directed_rows[i].forward;
         cmd.motor_stop = directed_rows[i].motor_stop;
         frame = command_frame(cmd);
         if (directed_rows[i].typed) begin
            frame[POS_ENABLE] = directed_rows[i].enable_byte;
            frame[POS_SPEED]  = directed_rows[i].speed_byte;
            frame[POS_DIR]    = directed_rows[i].dir_byte;
         end
         send_command(cmd, frame, directed_rows[i].gap);
      end

      repeat (RANDOM_CMDS) begin
         cmd   = cmd_type'($urandom_range(0, 1023));
         frame = command_frame(cmd);
         send_command(cmd, frame, ($urandom_range(0, 99) < 45) ? 0 : idle_length());
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // let the last frames drain, then watch for stray bytes
      while (pending_frame_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && pending_frame_bytes.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/mcf_pkg.sv
hw/rtl/mcf_if.sv
hw/rtl/mcf_crc_unit.sv
hw/rtl/motor_command_frame_crc16.sv
tb/sv/tb_motor_command_frame_crc16.sv
